FILE: rtl/pepv_pkg.sv
// ============================================================================
// pepv_pkg
// Shared types, character constants and helper functions for the URL path
// validator.
// ============================================================================
package pepv_pkg;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [15:0] CH_PERCENT   = 16'h0025;
    localparam logic [15:0] CH_SLASH     = 16'h002F;
    localparam logic [7:0]  BYTE_NUL     = 8'h00;
    localparam logic [7:0]  BYTE_SLASH   = 8'h2F;
    localparam logic [7:0]  BYTE_BSLASH  = 8'h5C;

    // Configuration register indexes (word address bit 2).
    localparam logic REG_ALLOW_EMPTY    = 1'b0;
    localparam logic REG_REJECT_TRAIL   = 1'b1;

    typedef struct packed {
        logic allow_empty;
        logic reject_trailing_slash;
    } pepv_cfg_t;

    // Strict UTF-8 decoder states. Each tail state records how many
    // continuation bytes remain and which range the next one must lie in.
    typedef enum logic [2:0] {
        U8_IDLE  = 3'd0,
        U8_TAIL1 = 3'd1,
        U8_TAIL2 = 3'd2,
        U8_TAIL3 = 3'd3,
        U8_E0    = 3'd4,
        U8_ED    = 3'd5,
        U8_F0    = 3'd6,
        U8_F4    = 3'd7
    } utf8_state_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] nibble;
    } hex_t;

    function automatic hex_t hex_value(input logic [6:0] c);
        hex_t h;
        h.valid  = 1'b1;
        h.nibble = 4'd0;
        if (c >= 7'h30 && c <= 7'h39) begin
            h.nibble = 4'(c - 7'h30);
        end else if (c >= 7'h61 && c <= 7'h66) begin
            h.nibble = 4'(c - 7'h57);
        end else if (c >= 7'h41 && c <= 7'h46) begin
            h.nibble = 4'(c - 7'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    // Unreserved and sub-delimiter characters, plus ':' '@' and '/'.
    function automatic logic is_path_char(input logic [6:0] c);
        logic r;
        r = 1'b0;
        if ((c >= 7'h61 && c <= 7'h7A) || (c >= 7'h41 && c <= 7'h5A) ||
            (c >= 7'h30 && c <= 7'h39)) begin
            r = 1'b1;
        end else begin
            case (c)
                7'h2D, 7'h2E, 7'h5F, 7'h7E, 7'h21, 7'h24, 7'h26, 7'h27,
                7'h28, 7'h29, 7'h2A, 7'h2B, 7'h2C, 7'h3B, 7'h3D, 7'h3A,
                7'h40, 7'h2F: r = 1'b1;
                default:      r = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

FILE: rtl/percent_encoded_path_validator.sv
// ============================================================================
// percent_encoded_path_validator
// Checks a percent-encoded URL path one 16-bit code unit per transaction and
// gives a single pass/fail verdict on the last character or on an empty-path
// transaction.
// ============================================================================
// Timing: the transaction that closes the path is first taken into the input
//   register; its verdict is loaded into the result register when it advances
//   from there, with out_valid rising then. A stalled, full result register can hold this off.
// Throughput: one transaction per cycle while out_stall does not hold the
//   result register, with the path core state update between the two registers.
// Reset: rst_n clears both configuration bits, the path state and the valid
//   flags of both registers; no clearing pass is needed.
module percent_encoded_path_validator (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [15:0]                    code_unit,
    input  logic                           last,
    input  logic                           empty_path,
    // Output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           path_ok,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pepv_pkg::PADDR_W-1:0]   paddr,
    input  logic [pepv_pkg::PDATA_W-1:0]   pwdata,
    output logic [pepv_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import pepv_pkg::*;

    pepv_cfg_t   cfg;

    // Input register: holds one transaction until the core processes it.
    logic        in_v_reg;
    logic [15:0] code_unit_reg;
    logic        last_reg;
    logic        empty_reg;

    // Result register.
    logic        out_v_reg,   out_v_next;
    logic        path_ok_reg;

    logic        has_result;
    logic        out_free;
    logic        advance;
    logic        verdict;

    pepv_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pepv_path_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .code_unit  (code_unit_reg),
        .last       (last_reg),
        .empty_path (empty_reg),
        .cfg        (cfg),
        .verdict    (verdict)
    );

    // A held transaction that produces no verdict always moves on. One that
    // produces a verdict moves on when the result register is empty or is
    // being emptied in this cycle.
    assign has_result = last_reg || empty_reg;
    assign out_free   = !out_v_reg || !out_stall;
    assign advance    = in_v_reg && (!has_result || out_free);
    assign in_stall   = in_v_reg && !advance;

    always_comb
    begin
        if (advance && has_result)
        begin
            out_v_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_v_next = out_v_reg;
        end
        else
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_v_reg <= in_valid;
            end
            out_v_reg <= out_v_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            code_unit_reg <= code_unit;
            last_reg      <= last;
            empty_reg     <= empty_path;
        end
        if (advance && has_result)
        begin
            path_ok_reg <= verdict;
        end
    end

    assign out_valid = out_v_reg;
    assign path_ok   = path_ok_reg;

endmodule

FILE: rtl/pepv_cfg_regs.sv
// ============================================================================
// pepv_cfg_regs
// APB-style configuration registers: allow_empty and reject_trailing_slash.
// ============================================================================
module pepv_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pepv_pkg::PADDR_W-1:0]   paddr,
    input  logic [pepv_pkg::PDATA_W-1:0]   pwdata,
    output logic [pepv_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output pepv_pkg::pepv_cfg_t            cfg
);
    import pepv_pkg::*;

    logic allow_empty_reg;
    logic reject_trail_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_empty_reg  <= 1'b0;
            reject_trail_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_ALLOW_EMPTY:  allow_empty_reg  <= pwdata[0];
                REG_REJECT_TRAIL: reject_trail_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_ALLOW_EMPTY:  prdata[0] = allow_empty_reg;
            REG_REJECT_TRAIL: prdata[0] = reject_trail_reg;
            default:          prdata = '0;
        endcase
    end

    assign cfg.allow_empty           = allow_empty_reg;
    assign cfg.reject_trailing_slash = reject_trail_reg;

endmodule

FILE: rtl/pepv_utf8_step.sv
// ============================================================================
// pepv_utf8_step
// One step of the strict UTF-8 decoder: next state and an ok flag.
// ============================================================================
module pepv_utf8_step (
    input  pepv_pkg::utf8_state_t state,
    input  logic [7:0]            data_byte,
    output pepv_pkg::utf8_state_t next_state,
    output logic                  ok
);
    import pepv_pkg::*;

    logic [7:0]  lo;
    logic [7:0]  hi;
    utf8_state_t tail_next;

    always_comb
    begin
        lo         = 8'h80;
        hi         = 8'hBF;
        tail_next  = U8_IDLE;
        next_state = state;
        ok         = 1'b1;
        unique case (state)
            U8_IDLE:  ;
            U8_TAIL1: tail_next = U8_IDLE;
            U8_TAIL2: tail_next = U8_TAIL1;
            U8_TAIL3: tail_next = U8_TAIL2;
            U8_E0:    begin tail_next = U8_TAIL1; lo = 8'hA0; end
            U8_ED:    begin tail_next = U8_TAIL1; hi = 8'h9F; end
            U8_F0:    begin tail_next = U8_TAIL2; lo = 8'h90; end
            U8_F4:    begin tail_next = U8_TAIL2; hi = 8'h8F; end
            default:  ok = 1'b0;
        endcase

        if (state == U8_IDLE)
        begin
            if (!data_byte[7])                                next_state = U8_IDLE;
            else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) next_state = U8_TAIL1;
            else if (data_byte == 8'hE0)                      next_state = U8_E0;
            else if (data_byte == 8'hED)                      next_state = U8_ED;
            else if (data_byte >= 8'hE1 && data_byte <= 8'hEF) next_state = U8_TAIL2;
            else if (data_byte == 8'hF0)                      next_state = U8_F0;
            else if (data_byte >= 8'hF1 && data_byte <= 8'hF3) next_state = U8_TAIL3;
            else if (data_byte == 8'hF4)                      next_state = U8_F4;
            else                                              ok = 1'b0;
        end
        else if (data_byte < lo || data_byte > hi)
        begin
            ok = 1'b0;
        end
        else
        begin
            next_state = tail_next;
        end
    end

endmodule

FILE: rtl/pepv_path_core.sv
// ============================================================================
// pepv_path_core
// Per-path state and the combinational character check. State moves forward
// on each processed item and clears after every verdict.
// ============================================================================
module pepv_path_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [15:0]         code_unit,
    input  logic                last,
    input  logic                empty_path,
    input  pepv_pkg::pepv_cfg_t cfg,
    output logic                verdict
);
    import pepv_pkg::*;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_t;

    logic        at_start_reg,    at_start_next;
    esc_t        esc_reg,         esc_next;
    logic [3:0]  nibble_reg,      nibble_next;
    logic        rejected_reg,    rejected_next;
    logic        slash_next;
    utf8_state_t u8_reg,          u8_next;

    logic        is_ascii;
    hex_t        hex;
    logic [7:0]  feed_byte;
    utf8_state_t u8_step_state;
    logic        u8_step_ok;
    logic        path_ok;
    logic        end_of_path;

    assign is_ascii = (code_unit[15:7] == '0);
    assign hex      = hex_value(code_unit[6:0]);

    assign feed_byte = (esc_reg == ESC_LOW) ? {nibble_reg, hex.nibble}
                                            : {1'b0, code_unit[6:0]};

    pepv_utf8_step u_utf8 (
        .state      (u8_reg),
        .data_byte  (feed_byte),
        .next_state (u8_step_state),
        .ok         (u8_step_ok)
    );

    always_comb
    begin
        at_start_next = 1'b0;
        esc_next      = esc_reg;
        nibble_next   = nibble_reg;
        rejected_next = rejected_reg;
        slash_next    = 1'b0;
        u8_next       = u8_reg;

        if (at_start_reg && code_unit != CH_SLASH)
        begin
            rejected_next = 1'b1;
        end

        case (esc_reg)
            ESC_HIGH:
            begin
                if (!(is_ascii && hex.valid)) rejected_next = 1'b1;
                else                          nibble_next   = hex.nibble;
                esc_next = ESC_LOW;
            end
            ESC_LOW:
            begin
                if (!(is_ascii && hex.valid))
                begin
                    rejected_next = 1'b1;
                end
                else if (feed_byte == BYTE_NUL || feed_byte == BYTE_SLASH ||
                         feed_byte == BYTE_BSLASH)
                begin
                    rejected_next = 1'b1;
                end
                else if (!u8_step_ok)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    u8_next = u8_step_state;
                end
                esc_next = ESC_NONE;
            end
            default:
            begin
                if (code_unit == CH_PERCENT)
                begin
                    esc_next = ESC_HIGH;
                end
                else if (!is_ascii || !is_path_char(code_unit[6:0]))
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    if (!u8_step_ok) rejected_next = 1'b1;
                    else             u8_next       = u8_step_state;
                    slash_next = (code_unit == CH_SLASH);
                end
            end
        endcase
    end

    // The trailing-slash flag only matters for the character that closes the
    // path, so it is used straight from the combinational update.
    assign path_ok = !rejected_next && (esc_next == ESC_NONE) && (u8_next == U8_IDLE) &&
                     !(cfg.reject_trailing_slash && slash_next);
    assign verdict     = empty_path ? cfg.allow_empty : path_ok;
    assign end_of_path = empty_path || last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
            esc_reg      <= ESC_NONE;
            nibble_reg   <= 4'd0;
            rejected_reg <= 1'b0;
            u8_reg       <= U8_IDLE;
        end
        else if (advance)
        begin
            if (end_of_path)
            begin
                at_start_reg <= 1'b1;
                esc_reg      <= ESC_NONE;
                nibble_reg   <= 4'd0;
                rejected_reg <= 1'b0;
                u8_reg       <= U8_IDLE;
            end
            else
            begin
                at_start_reg <= at_start_next;
                esc_reg      <= esc_next;
                nibble_reg   <= nibble_next;
                rejected_reg <= rejected_next;
                u8_reg       <= u8_next;
            end
        end
    end

endmodule

FILE: dv/percent_encoded_path_validator_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// percent_encoded_path_validator_tb
// Self-checking bench for the URL path validator. It sends whole paths one
// code unit per transaction, predicts each verdict with its own model of the
// path, escape and UTF-8 rules, and checks every verdict as it leaves the
// block. Both channels idle at random, and the configuration port is
// exercised with writes and read-back checks between phases.
// ============================================================================
module percent_encoded_path_validator_tb;

    import pepv_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int VERDICT_LATENCY = 2;
    localparam int MAX_IDLE        = 6;
    localparam int RUN_LIMIT_NS    = 3_000_000;

    // Escape tracking in the predictor: none, expecting the high hex digit,
    // expecting the low hex digit.
    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    // ------------------------------------------------------------------------
    // Block connections
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [15:0]          code_unit;
    logic                 last;
    logic                 empty_path;
    logic                 out_valid;
    logic                 out_stall;
    logic                 path_ok;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    percent_encoded_path_validator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_unit  (code_unit),
        .last       (last),
        .empty_path (empty_path),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .path_ok    (path_ok),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // Verdicts that the predictor has produced and the block still owes.
    logic        expected_verdicts[$];
    // The path under construction before it is sent.
    logic [15:0] path_units[$];

    // Characters that may appear raw in a path.
    string path_alphabet =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~!$&'()*+,;=:@/";

    int max_gap    = MAX_IDLE;
    int max_stall  = MAX_IDLE;
    int stall_left = 0;

    int n_units    = 0;
    int n_verdicts = 0;
    int n_passing  = 0;
    int n_errors   = 0;

    // Predictor copy of the configuration registers and the path state.
    logic        cfg_allow_empty;
    logic        cfg_reject_trail;
    logic        st_at_start;
    logic [1:0]  st_esc;
    logic [3:0]  st_high;
    logic        st_bad;
    logic        st_raw_slash;
    utf8_state_t st_u8;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A correct run needs far less than this even with every stall at its
    // longest, so reaching it means the block has hung.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d verdicts still owed.", expected_verdicts.size());
        $display("percent_encoded_path_validator_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        n_errors++;
        $display("ERROR at %0t ns: %s", $time, what);
    endtask

    function automatic void clear_path_state();
        st_at_start  = 1'b1;
        st_esc       = ESC_NONE;
        st_high      = 4'd0;
        st_bad       = 1'b0;
        st_raw_slash = 1'b0;
        st_u8        = U8_IDLE;
    endfunction

    // Returns {is_hex, value}. Anything above ASCII falls outside every range.
    function automatic logic [4:0] hex_of(input logic [15:0] c);
        if (c >= 16'h30 && c <= 16'h39)
            return {1'b1, 4'(c - 16'h30)};
        if (c >= 16'h61 && c <= 16'h66)
            return {1'b1, 4'(c - 16'h61 + 16'd10)};
        if (c >= 16'h41 && c <= 16'h46)
            return {1'b1, 4'(c - 16'h41 + 16'd10)};
        return 5'd0;
    endfunction

    function automatic logic path_char_ok(input logic [15:0] c);
        if ((c >= 16'h61 && c <= 16'h7A) || (c >= 16'h41 && c <= 16'h5A) ||
            (c >= 16'h30 && c <= 16'h39))
            return 1'b1;
        case (c)
            // - . _ ~ ! $ & ' ( ) * + , ; = : @ /
            16'h2D, 16'h2E, 16'h5F, 16'h7E, 16'h21, 16'h24, 16'h26, 16'h27,
            16'h28, 16'h29, 16'h2A, 16'h2B, 16'h2C, 16'h3B, 16'h3D, 16'h3A,
            16'h40, 16'h2F: return 1'b1;
            default:        return 1'b0;
        endcase
    endfunction

    // Strict UTF-8 decoding, one byte at a time. On an error the decoder
    // state is left as it was; the sticky reject flag takes over.
    function automatic logic utf8_accepts(input logic [7:0] b);
        logic [7:0]  lo;
        logic [7:0]  hi;
        utf8_state_t nxt;
        lo  = 8'h80;
        hi  = 8'hBF;
        nxt = U8_IDLE;
        case (st_u8)
            U8_IDLE:
            begin
                if (b <= 8'h7F)
                    st_u8 = U8_IDLE;
                else if (b >= 8'hC2 && b <= 8'hDF)
                    st_u8 = U8_TAIL1;
                else if (b == 8'hE0)
                    st_u8 = U8_E0;
                else if (b == 8'hED)
                    st_u8 = U8_ED;
                else if (b >= 8'hE1 && b <= 8'hEF)
                    st_u8 = U8_TAIL2;
                else if (b == 8'hF0)
                    st_u8 = U8_F0;
                else if (b >= 8'hF1 && b <= 8'hF3)
                    st_u8 = U8_TAIL3;
                else if (b == 8'hF4)
                    st_u8 = U8_F4;
                else
                    return 1'b0;
                return 1'b1;
            end
            U8_TAIL1: nxt = U8_IDLE;
            U8_TAIL2: nxt = U8_TAIL1;
            U8_TAIL3: nxt = U8_TAIL2;
            U8_E0:
            begin
                nxt = U8_TAIL1;
                lo  = 8'hA0;
            end
            U8_ED:
            begin
                nxt = U8_TAIL1;
                hi  = 8'h9F;
            end
            U8_F0:
            begin
                nxt = U8_TAIL2;
                lo  = 8'h90;
            end
            U8_F4:
            begin
                nxt = U8_TAIL2;
                hi  = 8'h8F;
            end
            default: return 1'b0;
        endcase
        if (b < lo || b > hi)
            return 1'b0;
        st_u8 = nxt;
        return 1'b1;
    endfunction

    // Advances the predicted path state by one accepted transaction and
    // queues a verdict where the transaction closes a path.
    function automatic void advance_path_model(input logic [15:0] cu, input logic lst,
                                               input logic emp);
        logic [4:0] h;
        logic [7:0] b;
        logic       ok;
        if (emp)
        begin
            // An empty-path transaction abandons any path in flight.
            clear_path_state();
            expected_verdicts.push_back(cfg_allow_empty);
            return;
        end
        if (st_at_start)
        begin
            if (cu != CH_SLASH)
                st_bad = 1'b1;
            st_at_start = 1'b0;
        end
        st_raw_slash = 1'b0;
        case (st_esc)
            ESC_HIGH:
            begin
                h = hex_of(cu);
                if (!h[4])
                    st_bad = 1'b1;
                else
                    st_high = h[3:0];
                st_esc = ESC_LOW;
            end
            ESC_LOW:
            begin
                h = hex_of(cu);
                if (!h[4])
                begin
                    st_bad = 1'b1;
                end
                else
                begin
                    b = {st_high, h[3:0]};
                    if (b == BYTE_NUL || b == BYTE_SLASH || b == BYTE_BSLASH)
                        st_bad = 1'b1;
                    else if (!utf8_accepts(b))
                        st_bad = 1'b1;
                end
                st_esc = ESC_NONE;
            end
            default:
            begin
                if (cu == CH_PERCENT)
                begin
                    st_esc = ESC_HIGH;
                end
                else if (!path_char_ok(cu))
                begin
                    st_bad = 1'b1;
                end
                else
                begin
                    if (!utf8_accepts(cu[7:0]))
                        st_bad = 1'b1;
                    st_raw_slash = (cu == CH_SLASH);
                end
            end
        endcase
        if (!lst)
            return;
        ok = !st_bad && st_esc == ESC_NONE && st_u8 == U8_IDLE &&
             !(cfg_reject_trail && st_raw_slash);
        clear_path_state();
        expected_verdicts.push_back(ok);
    endfunction

    // ------------------------------------------------------------------------
    // Output side: the stall pattern and the verdict checker
    // ------------------------------------------------------------------------
    // After every accepted verdict a fresh stall length is drawn; the stall
    // then runs down whether or not the next verdict is already waiting.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        logic want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    flag_mismatch($sformatf("verdict path_ok=%0b with no path closed", path_ok));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (path_ok !== want)
                        flag_mismatch($sformatf("verdict %0d: path_ok=%0b, predicted %0b",
                                                n_verdicts, path_ok, want));
                    n_verdicts++;
                    if (want)
                        n_passing++;
                end
                stall_left = $urandom_range(0, max_stall);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side and configuration port
    // ------------------------------------------------------------------------
    // Sends one transaction after a random gap and returns at the edge that
    // accepts it. Valid stays high across back-to-back transactions.
    task automatic send_unit(input logic [15:0] cu, input logic lst, input logic emp);
        int gap;
        gap = $urandom_range(0, max_gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        code_unit  <= cu;
        last       <= lst;
        empty_path <= emp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        advance_path_model(cu, lst, emp);
        n_units++;
    endtask

    task automatic send_path();
        foreach (path_units[i])
            send_unit(path_units[i], i == path_units.size() - 1, 1'b0);
        path_units.delete();
    endtask

    // Drops valid and waits until every owed verdict is out. A path left
    // unfinished owes nothing, so the wait then runs on past the verdict latency.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge clk);
        repeat (VERDICT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (idx == REG_ALLOW_EMPTY)
            cfg_allow_empty = value[0];
        else
            cfg_reject_trail = value[0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check_read(input logic idx, input logic want);
        logic [PDATA_W-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {{(PDATA_W-1){1'b0}}, want})
            flag_mismatch($sformatf("register %0d reads 0x%08h, written %0b", idx, got, want));
    endtask

    // Both registers are only touched once the block has gone quiet.
    task automatic set_registers(input logic allow_empty, input logic reject_trail);
        wait_idle();
        apb_write(REG_ALLOW_EMPTY, {{(PDATA_W-1){1'b0}}, allow_empty});
        apb_write(REG_REJECT_TRAIL, {{(PDATA_W-1){1'b0}}, reject_trail});
        apb_check_read(REG_ALLOW_EMPTY, allow_empty);
        apb_check_read(REG_REJECT_TRAIL, reject_trail);
    endtask

    // ------------------------------------------------------------------------
    // Path builders
    // ------------------------------------------------------------------------
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            path_units.push_back({8'h00, s[i]});
    endtask

    function automatic logic [15:0] hex_char(input logic [3:0] n, input logic lower);
        if (n < 4'd10)
            return 16'h30 + 16'(n);
        return (lower ? 16'h61 : 16'h41) + 16'(n) - 16'd10;
    endfunction

    // Escapes one byte, with the case of each letter digit chosen at random.
    task automatic push_escape(input logic [7:0] b);
        path_units.push_back(CH_PERCENT);
        path_units.push_back(hex_char(b[7:4], 1'($urandom_range(0, 1))));
        path_units.push_back(hex_char(b[3:0], 1'($urandom_range(0, 1))));
    endtask

    task automatic push_raw_char();
        path_units.push_back({8'h00, path_alphabet[$urandom_range(0, path_alphabet.len() - 1)]});
    endtask

    // A well-formed code point of one to four bytes, escaped byte by byte.
    // A quarter of them sit on the edges of their length class.
    task automatic push_codepoint();
        int          nbytes;
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        nbytes = $urandom_range(1, 4);
        case (nbytes)
            1:       begin lo = 21'h1;     hi = 21'h7F;     end
            2:       begin lo = 21'h80;    hi = 21'h7FF;    end
            3:       begin lo = 21'h800;   hi = 21'hFFFF;   end
            default: begin lo = 21'h10000; hi = 21'h10FFFF; end
        endcase
        if ($urandom_range(0, 3) == 0)
            cp = $urandom_range(0, 1) ? lo : hi;
        else
            cp = 21'($urandom_range(lo, hi));
        // Keep clear of surrogates; land on the nearest edges around them.
        if (cp >= 21'hD800 && cp <= 21'hDFFF)
            cp = $urandom_range(0, 1) ? 21'hD7FF : 21'hE000;
        case (nbytes)
            1:
                push_escape(cp[7:0]);
            2:
            begin
                push_escape({3'b110, cp[10:6]});
                push_escape({2'b10, cp[5:0]});
            end
            3:
            begin
                push_escape({4'b1110, cp[15:12]});
                push_escape({2'b10, cp[11:6]});
                push_escape({2'b10, cp[5:0]});
            end
            default:
            begin
                push_escape({5'b11110, cp[20:18]});
                push_escape({2'b10, cp[17:12]});
                push_escape({2'b10, cp[11:6]});
                push_escape({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // Malformed or forbidden material of many kinds.
    task automatic push_noise();
        case ($urandom_range(0, 7))
            0: path_units.push_back(16'($urandom_range(0, 16'hFFFF)));
            1: path_units.push_back(16'($urandom_range(0, 16'h7F)));
            2:
            begin
                // Escape whose digits may not be hex at all.
                path_units.push_back(CH_PERCENT);
                path_units.push_back(16'($urandom_range(0, 16'h7F)));
                path_units.push_back(16'($urandom_range(0, 16'h7F)));
            end
            3:
            begin
                // Decoded bytes that a path may never carry.
                case ($urandom_range(0, 2))
                    0:       push_escape(BYTE_NUL);
                    1:       push_escape(BYTE_SLASH);
                    default: push_escape(BYTE_BSLASH);
                endcase
            end
            4: push_escape(8'($urandom_range(0, 8'hFF)));
            5:
            begin
                // A lead byte and at most one continuation byte; the sequence is often cut short.
                push_escape(8'($urandom_range(8'hC2, 8'hF4)));
                if ($urandom_range(0, 1))
                    push_escape(8'($urandom_range(8'h80, 8'hBF)));
            end
            6:
            begin
                // Overlong forms, surrogates, values past the last code
                // point, bad lead bytes and stray continuation bytes.
                case ($urandom_range(0, 6))
                    0:
                    begin
                        push_escape(8'($urandom_range(8'hC0, 8'hC1)));
                        push_escape(8'h80);
                    end
                    1:
                    begin
                        push_escape(8'hE0);
                        push_escape(8'($urandom_range(8'h80, 8'h9F)));
                        push_escape(8'h80);
                    end
                    2:
                    begin
                        push_escape(8'hED);
                        push_escape(8'($urandom_range(8'hA0, 8'hBF)));
                        push_escape(8'h80);
                    end
                    3:
                    begin
                        push_escape(8'hF0);
                        push_escape(8'($urandom_range(8'h80, 8'h8F)));
                        push_escape(8'hBF);
                        push_escape(8'hBF);
                    end
                    4:
                    begin
                        push_escape(8'hF4);
                        push_escape(8'($urandom_range(8'h90, 8'hBF)));
                        push_escape(8'h80);
                        push_escape(8'h80);
                    end
                    5:
                    begin
                        push_escape(8'($urandom_range(8'hF5, 8'hFF)));
                        push_escape(8'h80);
                    end
                    default: push_escape(8'($urandom_range(8'h80, 8'hBF)));
                endcase
            end
            default:
            begin
                // Escape digit above ASCII.
                path_units.push_back(CH_PERCENT);
                path_units.push_back(16'($urandom_range(16'h80, 16'hFFFF)));
                if ($urandom_range(0, 1))
                    path_units.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
            end
        endcase
    endtask

    // Mostly well-formed paths with random content; a quarter carry noise.
    task automatic build_random_path();
        int   n_parts;
        int   r;
        logic noisy;
        path_units.delete();
        if ($urandom_range(0, 99) < 4)
        begin
            if ($urandom_range(0, 1))
                push_raw_char();
            else
                path_units.push_back(16'($urandom_range(0, 16'hFFFF)));
        end
        else
        begin
            path_units.push_back(CH_SLASH);
        end
        noisy   = ($urandom_range(0, 99) < 25);
        n_parts = $urandom_range(0, 6);
        repeat (n_parts)
        begin
            r = $urandom_range(0, 99);
            if (noisy && r < 20)
                push_noise();
            else if (r < 45)
                push_raw_char();
            else if (r < 55)
                path_units.push_back(CH_SLASH);
            else if (r < 90)
                push_codepoint();
            else
                push_escape(8'($urandom_range(1, 8'h7F)));
        end
        // Endings: a trailing raw slash, or on noisy paths an escape left open.
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            path_units.push_back(CH_SLASH);
        end
        else if (noisy && r < 30)
        begin
            path_units.push_back(CH_PERCENT);
            if ($urandom_range(0, 1))
                path_units.push_back(hex_char(4'($urandom_range(0, 15)), 1'b1));
        end
    endtask

    // Random traffic until the given number of transactions has gone in.
    // Some paths are abandoned part way by an empty-path transaction, and
    // empty-path transactions also arrive on their own.
    task automatic run_random_paths(input int n_target);
        int first;
        int r;
        int cut;
        first = n_units;
        while (n_units - first < n_target)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                send_unit(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)), 1'b1);
            end
            else
            begin
                build_random_path();
                if (r < 8)
                begin
                    cut = $urandom_range(1, path_units.size());
                    for (int i = 0; i < cut; i++)
                        send_unit(path_units[i], 1'b0, 1'b0);
                    path_units.delete();
                    send_unit(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)), 1'b1);
                end
                else
                begin
                    send_path();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Registers come out of reset cleared, so an empty path is refused.
    task automatic test_reset_defaults();
        apb_check_read(REG_ALLOW_EMPTY, 1'b0);
        apb_check_read(REG_REJECT_TRAIL, 1'b0);
        send_unit(16'hFFFF, 1'b1, 1'b1);
    endtask

    // Allow-empty set, with trailing-slash rejection on and then off, each with a path that shows its effect.
    task automatic test_register_effects();
        set_registers(1'b1, 1'b1);
        send_unit(16'h0000, 1'b0, 1'b1);
        push_text("/");
        send_path();
        set_registers(1'b1, 1'b0);
        push_text("/");
        send_path();
    endtask

    task automatic test_directed_paths();
        set_registers(1'b0, 1'b0);
        // Two-byte character escaped with mixed-case hex digits.
        push_text("/%c3%A9");
        send_path();
        // The same character with its continuation byte missing.
        push_text("/%C3");
        send_path();
        // An escaped slash is refused.
        push_text("/%2f");
        send_path();
        // A path must open with a raw slash.
        push_text("x");
        send_path();
        // An escape still open when the path ends.
        push_text("/%4");
        send_path();
        // Code unit extremes: the top of the range, then a lone zero.
        path_units.push_back(CH_SLASH);
        path_units.push_back(16'hFFFF);
        send_path();
        path_units.push_back(16'h0000);
        send_path();
        // An empty path arriving mid-path abandons it; last is ignored.
        send_unit(CH_SLASH, 1'b0, 1'b0);
        send_unit(16'h0000, 1'b1, 1'b1);
    endtask

    // Random traffic under all four register settings, with random idling.
    task automatic test_random_paths();
        for (int setting = 0; setting < 4; setting++)
        begin
            set_registers(setting[1], setting[0]);
            run_random_paths(280);
        end
    endtask

    // Neither side idles: transactions and verdicts move every cycle.
    task automatic test_back_to_back();
        set_registers(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        max_gap   = 0;
        max_stall = 0;
        run_random_paths(180);
        wait_idle();
        max_gap   = MAX_IDLE;
        max_stall = MAX_IDLE;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        code_unit  = 16'h0000;
        last       = 1'b0;
        empty_path = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cfg_allow_empty  = 1'b0;
        cfg_reject_trail = 1'b0;
        clear_path_state();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_effects();
        test_directed_paths();
        test_random_paths();
        test_back_to_back();
        wait_idle();

        $display("Sent %0d transactions; checked %0d verdicts, %0d of them accepting.",
                 n_units, n_verdicts, n_passing);
        $display("Exercised all register settings, escapes, UTF-8 errors and abandoned paths.");
        if (n_errors == 0)
            $display("percent_encoded_path_validator_tb passed");
        else
            $display("percent_encoded_path_validator_tb failed");
        $finish;
    end

endmodule
